/* rtl/bdq_pkg.sv */
// shared constants and types for the bounded deque
package bdq_pkg;

   localparam int unsigned CAPACITY_DEF = 16;
   localparam int unsigned VALUE_W      = 32;
   localparam int unsigned CMD_W        = 3;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } status_type;

endpackage

/* rtl/bdq_ram.sv */
// entry store: one write port, one read port with registered read data
module bdq_ram #(
   parameter int unsigned DEPTH = bdq_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [bdq_pkg::VALUE_W-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [bdq_pkg::VALUE_W-1:0]         rd_data
);

   logic [bdq_pkg::VALUE_W-1:0] entry_mem [DEPTH];
   logic [bdq_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bounded_deque_remove_by_value.sv */
// bounded deque of signed words with remove by value, top level
//
// commands enter on start/req_cmd/req_value and are taken when busy is low;
// busy stays high until the result beat has been produced.
// every command gives exactly one result beat: rsp_strobe is high for one
// cycle with status, count and the front and back values after the command.
// entries sit in a ring inside a one-port-read memory; head and tail
// pointers move for pushes and pops, and every command then passes the
// front read, back read and finish states before the result strobe.
// remove by value makes one pass over the held entries: each cycle reads
// one entry, compares it, and once the match is seen writes each later
// entry one place toward the front; the scan covers up to CAPACITY entries.
// the front and back values are read back from the memory after every
// command, one read each.
// reset empties the store at once; the memory needs no clearing.
// the result beat cannot be held off; a new command may be accepted in
// the cycle in which the result strobe is high.
module bounded_deque_remove_by_value #(
   parameter int unsigned CAPACITY = bdq_pkg::CAPACITY_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [bdq_pkg::CMD_W-1:0]               req_cmd,
   input  logic signed [bdq_pkg::VALUE_W-1:0]      req_value,
   output logic                                    rsp_strobe,
   output logic [1:0]                              rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]           rsp_count,
   output logic signed [bdq_pkg::VALUE_W-1:0]      rsp_front_value,
   output logic signed [bdq_pkg::VALUE_W-1:0]      rsp_back_value
);

   localparam int unsigned PW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned VW = bdq_pkg::VALUE_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_RDF  = 5'b00100,
      ST_RDB  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           held_ff, held_in;
   logic [PW-1:0]           head_ff, head_in;
   logic [PW-1:0]           tail_ff, tail_in;
   logic [PW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]           cur_addr_ff, cur_addr_in;
   logic [CW-1:0]           rd_left_ff, rd_left_in;
   logic                    vld_ff, vld_in;
   logic                    found_ff, found_in;
   logic [VW-1:0]           val_ff, val_in;
   bdq_pkg::status_type     status_ff, status_in;
   logic [VW-1:0]           front_ff, front_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [CW-1:0]           rsp_count_ff, rsp_count_in;
   logic [VW-1:0]           rsp_front_ff, rsp_front_in;
   logic [VW-1:0]           rsp_back_ff, rsp_back_in;

   logic                    wr_en;
   logic [PW-1:0]           wr_addr;
   logic [VW-1:0]           wr_data;
   logic [PW-1:0]           rd_addr;
   logic [VW-1:0]           rd_data;
   logic                    full;
   logic                    empty;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
      return (p == '0) ? PW'(CAPACITY - 1) : p - 1'b1;
   endfunction

   bdq_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full  = (held_ff == CW'(CAPACITY));
   assign empty = (held_ff == '0);

   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rd_ptr_in     = rd_ptr_ff;
      cur_addr_in   = cur_addr_ff;
      rd_left_in    = rd_left_ff;
      vld_in        = vld_ff;
      found_in      = found_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      front_in      = front_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      wr_data       = req_value;
      rd_addr       = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               val_in    = req_value;
               status_in = bdq_pkg::STATUS_OK;
               state_in  = ST_RDF;
               case (req_cmd)
                  bdq_pkg::CMD_PUSH_FRONT: begin
                     if (full) begin
                        status_in = bdq_pkg::STATUS_FULL;
                     end else begin
                        head_in = ptr_dec(head_ff);
                        wr_en   = 1'b1;
                        wr_addr = ptr_dec(head_ff);
                        if (empty) begin
                           tail_in = ptr_dec(head_ff);
                        end
                        held_in = held_ff + 1'b1;
                     end
                  end
                  bdq_pkg::CMD_PUSH_BACK: begin
                     if (full) begin
                        status_in = bdq_pkg::STATUS_FULL;
                     end else begin
                        wr_en = 1'b1;
                        if (empty) begin
                           wr_addr = head_ff;
                           tail_in = head_ff;
                        end else begin
                           wr_addr = ptr_inc(tail_ff);
                           tail_in = ptr_inc(tail_ff);
                        end
                        held_in = held_ff + 1'b1;
                     end
                  end
                  bdq_pkg::CMD_POP_FRONT: begin
                     if (empty) begin
                        status_in = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        head_in = ptr_inc(head_ff);
                        held_in = held_ff - 1'b1;
                     end
                  end
                  bdq_pkg::CMD_POP_BACK: begin
                     if (empty) begin
                        status_in = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        tail_in = ptr_dec(tail_ff);
                        held_in = held_ff - 1'b1;
                     end
                  end
                  bdq_pkg::CMD_REMOVE: begin
                     if (empty) begin
                        status_in = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        state_in   = ST_SCAN;
                        rd_ptr_in  = head_ff;
                        rd_left_in = held_ff;
                        vld_in     = 1'b0;
                        found_in   = 1'b0;
                     end
                  end
                  bdq_pkg::CMD_CLEAR: begin
                     held_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // compare the entry read last cycle; after the match, move it up one place
            if (vld_ff) begin
               if (!found_ff) begin
                  if (rd_data == val_ff) begin
                     found_in = 1'b1;
                  end
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = ptr_dec(cur_addr_ff);
                  wr_data = rd_data;
               end
            end
            if (rd_left_ff != '0) begin
               rd_addr     = rd_ptr_ff;
               cur_addr_in = rd_ptr_ff;
               rd_ptr_in   = ptr_inc(rd_ptr_ff);
               rd_left_in  = rd_left_ff - 1'b1;
               vld_in      = 1'b1;
            end else begin
               vld_in = 1'b0;
            end
            if ((rd_left_ff == '0) && !vld_ff) begin
               state_in = ST_RDF;
               if (found_ff) begin
                  held_in = held_ff - 1'b1;
                  tail_in = ptr_dec(tail_ff);
               end else begin
                  status_in = bdq_pkg::STATUS_NOTFOUND;
               end
            end
         end
         ST_RDF: begin
            rd_addr  = head_ff;
            state_in = ST_RDB;
         end
         ST_RDB: begin
            rd_addr  = tail_ff;
            front_in = rd_data;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = status_ff;
            rsp_count_in  = held_ff;
            rsp_front_in  = empty ? '0 : front_ff;
            rsp_back_in   = empty ? '0 : rd_data;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         vld_ff        <= 1'b0;
         found_ff      <= 1'b0;
         rd_left_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         vld_ff        <= vld_in;
         found_ff      <= found_in;
         rd_left_ff    <= rd_left_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      cur_addr_ff   <= cur_addr_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      front_ff      <= front_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_count == '0)) |-> (rsp_front_value == '0 && rsp_back_value == '0))
      else $error("empty result with nonzero front or back");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_IDLE && $past(state_ff == ST_FIN)))
      else $error("result beat outside of command completion");

endmodule

/* dv/bounded_deque_remove_by_value_test.sv */
// self-checking testbench for the bounded deque with remove by value
module bounded_deque_remove_by_value_test;
   import bdq_pkg::*;

   localparam int unsigned COUNT_W     = $clog2(CAPACITY_DEF + 1);
   localparam int unsigned RANDOM_CMDS = 2000;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_WAIT  = CAPACITY_DEF + 20;
   localparam int unsigned CALM_TAIL   = 150;

   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]          cmd;
      logic signed [VALUE_W-1:0] val;
   } cmd_beat_t;

   typedef struct {
      status_type                status;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] front;
      logic signed [VALUE_W-1:0] back;
   } outcome_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CMD_W-1:0] req_cmd = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic rsp_strobe;
   logic [1:0] rsp_status;
   logic [COUNT_W-1:0] rsp_count;
   logic signed [VALUE_W-1:0] rsp_front_value;
   logic signed [VALUE_W-1:0] rsp_back_value;

   cmd_beat_t pending_cmds[$];
   outcome_t outcome_q[$];
   logic signed [VALUE_W-1:0] deque_model[$];

   int unsigned errors = 0;
   int unsigned cycle_count = 0;
   int unsigned n_accepted = 0;
   int unsigned n_results = 0;
   int unsigned n_full = 0;
   int unsigned n_empty = 0;
   int unsigned n_missing = 0;
   int unsigned n_removed = 0;
   int unsigned n_at_capacity = 0;

   bounded_deque_remove_by_value dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_front_value(rsp_front_value),
      .rsp_back_value(rsp_back_value)
   );

   always #5 clock = ~clock;

   function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] val);
      cmd_beat_t b;
      b.cmd = cmd;
      b.val = val;
      pending_cmds.push_back(b);
   endfunction

   // apply one command to the model deque and record the expected result beat
   function automatic void deque_apply(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] val);
      outcome_t o;
      int hit;
      o.status = STATUS_OK;
      hit = -1;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (deque_model.size() >= CAPACITY_DEF) begin
               o.status = STATUS_FULL;
            end else if (cmd == CMD_PUSH_FRONT) begin
               deque_model.push_front(val);
            end else begin
               deque_model.push_back(val);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (deque_model.size() == 0) begin
               o.status = STATUS_EMPTY;
            end else if (cmd == CMD_POP_FRONT) begin
               void'(deque_model.pop_front());
            end else begin
               void'(deque_model.pop_back());
            end
         end
         CMD_REMOVE: begin
            if (deque_model.size() == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               for (int i = 0; i < deque_model.size(); i++) begin
                  if (hit < 0 && deque_model[i] == val) hit = i;
               end
               if (hit < 0) begin
                  o.status = STATUS_NOTFOUND;
               end else begin
                  deque_model.delete(hit);
                  n_removed++;
               end
            end
         end
         CMD_CLEAR: begin
            deque_model.delete();
         end
         default: begin
         end
      endcase
      o.count = COUNT_W'(deque_model.size());
      o.front = (deque_model.size() == 0) ? '0 : deque_model[0];
      o.back  = (deque_model.size() == 0) ? '0 : deque_model[deque_model.size() - 1];
      if (o.status == STATUS_FULL) n_full++;
      if (o.status == STATUS_EMPTY) n_empty++;
      if (o.status == STATUS_NOTFOUND) n_missing++;
      if (deque_model.size() == CAPACITY_DEF) n_at_capacity++;
      outcome_q.push_back(o);
   endfunction

   // driver
   always @(posedge clock) begin : drive
      int unsigned idle_left;
      int unsigned idle_pct;
      int unsigned sent;
      cmd_beat_t nxt;
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
         idle_pct = 0;
         sent = 0;
      end else begin
         if (start && !busy) begin
            deque_apply(req_cmd, req_value);
            n_accepted++;
         end
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
               start <= 1'b0;
            end else if (pending_cmds.size() > CALM_TAIL && idle_pct > 0 &&
                         $urandom_range(0, 99) < idle_pct) begin
               idle_left = $urandom_range(1, 9) - 1;
               start <= 1'b0;
            end else begin
               nxt = pending_cmds.pop_front();
               start <= 1'b1;
               req_cmd <= nxt.cmd;
               req_value <= nxt.val;
               sent++;
               if (sent % 64 == 0) idle_pct = $urandom_range(0, 3) * 10;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      outcome_t e;
      if (!reset && rsp_strobe) begin
         n_results++;
         if (outcome_q.size() == 0) begin
            $error("result beat with no expectation: status %0d count %0d",
                   rsp_status, rsp_count);
            errors++;
         end else begin
            e = outcome_q.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_count !== e.count) begin
               $error("count: expected %0d, got %0d", e.count, rsp_count);
               errors++;
            end
            if (rsp_front_value !== e.front) begin
               $error("front_value: expected %0d, got %0d", e.front, rsp_front_value);
               errors++;
            end
            if (rsp_back_value !== e.back) begin
               $error("back_value: expected %0d, got %0d", e.back, rsp_back_value);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : stimulus
      logic signed [VALUE_W-1:0] pool[8];
      int unsigned bias;
      int unsigned r;
      int unsigned push_pct;
      int unsigned pop_pct;
      logic signed [VALUE_W-1:0] v;

      // empty store corner cases
      queue_cmd(CMD_CLEAR, 0);
      queue_cmd(CMD_POP_FRONT, 0);
      queue_cmd(CMD_POP_BACK, 0);
      queue_cmd(CMD_REMOVE, 5);
      // extremes, absent value, removal from the middle, unused codes
      queue_cmd(CMD_PUSH_FRONT, 32'sh7fffffff);
      queue_cmd(CMD_PUSH_BACK, 32'sh80000000);
      queue_cmd(CMD_PUSH_FRONT, -1);
      queue_cmd(CMD_PUSH_BACK, 0);
      queue_cmd(CMD_REMOVE, 12345);
      queue_cmd(CMD_REMOVE, 32'sh7fffffff);
      queue_cmd(CMD_SPARE_6, 1);
      queue_cmd(CMD_SPARE_7, -1);
      // fill to capacity with duplicates, then push into a full store
      for (int i = 0; i < CAPACITY_DEF - 3; i++) begin
         queue_cmd((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, i % 4);
      end
      queue_cmd(CMD_PUSH_FRONT, 99);
      queue_cmd(CMD_PUSH_BACK, 99);
      queue_cmd(CMD_REMOVE, 2);
      queue_cmd(CMD_POP_FRONT, 0);
      queue_cmd(CMD_POP_BACK, 0);
      queue_cmd(CMD_CLEAR, 0);

      // random part: a small value pool so removals often hit
      pool[0] = 32'sh7fffffff;
      pool[1] = 32'sh80000000;
      for (int i = 2; i < 8; i++) begin
         pool[i] = (i < 5) ? $signed($urandom_range(0, 15)) : $signed($urandom);
      end
      bias = 0;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n % 50 == 0) bias = $urandom_range(0, 2);
         push_pct = (bias == 0) ? 65 : (bias == 1) ? 25 : 45;
         pop_pct  = (bias == 0) ? 10 : (bias == 1) ? 40 : 25;
         v = ($urandom_range(0, 3) == 0) ? $signed($urandom) : pool[$urandom_range(0, 7)];
         r = $urandom_range(0, 99);
         if (r < 2) begin
            queue_cmd(CMD_CLEAR, v);
         end else if (r < 4) begin
            queue_cmd($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7, v);
         end else if (r < 4 + push_pct) begin
            queue_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, v);
         end else if (r < 4 + push_pct + pop_pct) begin
            queue_cmd($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, v);
         end else begin
            queue_cmd(CMD_REMOVE, v);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (!(pending_cmds.size() == 0 && !start && outcome_q.size() == 0) &&
             cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
      end else begin
         repeat (DRAIN_WAIT) @(posedge clock);
         if (outcome_q.size() != 0) begin
            $error("%0d expected result beats never arrived", outcome_q.size());
            errors++;
         end
         $display("%0d commands accepted, %0d result beats checked, %0d mismatches",
                  n_accepted, n_results, errors);
         $display("%0d full drops, %0d empty, %0d not found, %0d removals, %0d at capacity",
                  n_full, n_empty, n_missing, n_removed, n_at_capacity);
         if (errors == 0) begin
            $display("CHECK OK");
         end else begin
            $display("CHECK FAILED");
         end
      end
      $finish;
   end

endmodule
